// ----- sv/i2cseq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package i2cseq_pkg;

   localparam int OP_DEPTH = 16;
   localparam int TX_DEPTH = 64;
   localparam int RX_DEPTH = 64;

   localparam int OP_AW = (OP_DEPTH > 1) ? $clog2(OP_DEPTH) : 1;
   localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

   localparam int OP_ENTRY_W = 24;

   typedef enum logic [1:0] {
      CMD_LOAD_OP = 2'd0,
      CMD_LOAD_TX = 2'd1,
      CMD_STATUS  = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SEND    = 3'd1,
      ACT_ACK     = 3'd2,
      ACT_NACK    = 3'd3,
      ACT_RESTART = 3'd4,
      ACT_STOP    = 3'd5
   } action_type;

   localparam logic [7:0] ST_MASK      = 8'hFC;
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_ADDR_WACK = 8'h18;
   localparam logic [7:0] ST_DATA_WACK = 8'h28;
   localparam logic [7:0] ST_ADDR_RACK = 8'h40;
   localparam logic [7:0] ST_DATA_RACK = 8'h50;
   localparam logic [7:0] ST_DATA_RNAK = 8'h58;
   localparam logic [7:0] ADDR_NO_RD   = 8'hFE;
   localparam logic [7:0] END_MARK     = 8'h01;

   typedef struct packed {
      logic [1:0] cmd;
      logic [5:0] slot;
      logic [7:0] addr_byte;
      logic [7:0] target_reg;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
      logic [7:0] bus_status;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] send_value;
      logic       rx_valid;
      logic [7:0] rx_value;
      logic [5:0] rx_slot;
      logic       done_res;
      logic       fault;
   } rsp_type;

   function automatic logic [OP_AW-1:0] op_inc(input logic [OP_AW-1:0] pos);
      op_inc = (pos == OP_AW'(OP_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] pos);
      tx_inc = (pos == TX_AW'(TX_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] pos);
      rx_inc = (pos == RX_AW'(RX_DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

endpackage
`default_nettype wire

// ----- sv/i2c_master_op_list_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  i2cseq_pkg::req_type
// rsp_      out        rsp_valid / rsp_stall  i2cseq_pkg::rsp_type
//
// One request per cycle while req_stall is low. A request is accepted at an edge and
// reads the op table and transmit store there; the read stage registers its response.
// Loads write the memories at the accept edge, so a status right behind sees them.
// Reset clears positions, counters and valids; the memories are not cleared.
// A stalled response holds the one request in the read stage and stalls req_.
module i2c_master_op_list_sequencer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire i2cseq_pkg::req_type  req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      i2cseq_pkg::rsp_type  rsp_data
);
   import i2cseq_pkg::*;

   logic                   req_accept;
   logic                   s1_go;
   logic                   s1_fire;
   logic                   s1_vld_ff;
   req_type                s1_req_ff;

   logic [OP_AW-1:0]       op_pos_ff,  op_pos_in,  op_pos_step;
   logic [TX_AW-1:0]       tx_pos_ff,  tx_pos_in,  tx_pos_step;
   logic [RX_AW-1:0]       rx_pos_ff,  rx_pos_in,  rx_pos_step;
   logic                   rd_pend_ff, rd_pend_in, rd_pend_step;
   logic [7:0]             remain_ff,  remain_in,  remain_step;

   logic                   rsp_vld_ff;
   rsp_type                rsp_data_ff;
   rsp_type                res;

   logic [OP_AW-1:0]       op_rd_addr;
   logic [OP_ENTRY_W-1:0]  cur_ent;
   logic [7:0]             nxt_addr;
   logic [7:0]             tx_byte;
   logic                   op_wr, tx_wr;
   logic [7:0]             code;
   logic [7:0]             ent_addr, ent_reg, ent_len;
   logic                   rd_pend_eff;
   logic [OP_AW-1:0]       op_adv;

   assign s1_go      = !rsp_vld_ff || !rsp_stall;
   assign req_stall  = s1_vld_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;
   assign s1_fire    = s1_vld_ff && s1_go;

   assign op_wr = req_accept && (req_data.cmd == CMD_LOAD_OP)
                  && (32'(req_data.slot) < 32'(OP_DEPTH));
   assign tx_wr = req_accept && (req_data.cmd == CMD_LOAD_TX)
                  && (32'(req_data.slot) < 32'(TX_DEPTH));

   // a start rewinds the list, so read entry zero for it
   assign op_rd_addr = ((req_data.cmd == CMD_STATUS)
                        && ((req_data.bus_status & ST_MASK) == ST_START)) ? '0 : op_pos_in;

   i2cseq_ram #(.WIDTH(OP_ENTRY_W), .DEPTH(OP_DEPTH)) u_op_cur (
      .clock   (clock),
      .wr_en   (op_wr),
      .wr_addr (OP_AW'(req_data.slot)),
      .wr_data ({req_data.addr_byte, req_data.target_reg, req_data.byte_count}),
      .rd_en   (req_accept),
      .rd_addr (op_rd_addr),
      .rd_data (cur_ent)
   );

   // copy of the address bytes, read one entry ahead for the end check
   i2cseq_ram #(.WIDTH(8), .DEPTH(OP_DEPTH)) u_op_nxt (
      .clock   (clock),
      .wr_en   (op_wr),
      .wr_addr (OP_AW'(req_data.slot)),
      .wr_data (req_data.addr_byte),
      .rd_en   (req_accept),
      .rd_addr (op_inc(op_pos_in)),
      .rd_data (nxt_addr)
   );

   i2cseq_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx (
      .clock   (clock),
      .wr_en   (tx_wr),
      .wr_addr (TX_AW'(req_data.slot)),
      .wr_data (req_data.data_byte),
      .rd_en   (req_accept),
      .rd_addr (tx_pos_in),
      .rd_data (tx_byte)
   );

   assign code     = s1_req_ff.bus_status & ST_MASK;
   assign ent_addr = cur_ent[23:16];
   assign ent_reg  = cur_ent[15:8];
   assign ent_len  = cur_ent[7:0];
   assign op_adv   = op_inc(op_pos_ff);

   always_comb begin
      op_pos_step  = op_pos_ff;
      tx_pos_step  = tx_pos_ff;
      rx_pos_step  = rx_pos_ff;
      rd_pend_step = rd_pend_ff;
      remain_step  = remain_ff;
      rd_pend_eff  = rd_pend_ff;
      res          = '0;
      if (s1_req_ff.cmd == CMD_STATUS) begin
         case (code)
            ST_START, ST_RESTART: begin
               if (code == ST_START) begin
                  op_pos_step = '0;
                  tx_pos_step = '0;
                  rx_pos_step = '0;
                  rd_pend_eff = 1'b0;
               end
               res.action = ACT_SEND;
               if (!rd_pend_eff) begin
                  rd_pend_step   = ent_addr[0];
                  res.send_value = ent_addr & ADDR_NO_RD;
               end else begin
                  rd_pend_step   = 1'b0;
                  res.send_value = (ent_addr & ADDR_NO_RD) | END_MARK;
               end
            end
            ST_ADDR_WACK: begin
               remain_step    = ent_len;
               res.action     = ACT_SEND;
               res.send_value = ent_reg;
            end
            ST_DATA_WACK: begin
               if (rd_pend_ff) begin
                  res.action = ACT_RESTART;
               end else if (remain_ff != 8'd0) begin
                  remain_step    = remain_ff - 8'd1;
                  res.action     = ACT_SEND;
                  res.send_value = tx_byte;
                  tx_pos_step    = tx_inc(tx_pos_ff);
               end else begin
                  op_pos_step  = op_adv;
                  res.done_res = (nxt_addr == END_MARK);
                  res.action   = (nxt_addr == END_MARK) ? ACT_STOP : ACT_RESTART;
               end
            end
            ST_ADDR_RACK, ST_DATA_RACK: begin
               if (code == ST_DATA_RACK) begin
                  res.rx_valid = 1'b1;
                  res.rx_value = s1_req_ff.data_byte;
                  res.rx_slot  = 6'(rx_pos_ff);
                  rx_pos_step  = rx_inc(rx_pos_ff);
               end
               // a zero count on address ack behaves as one byte
               if (remain_ff > 8'd1) begin
                  remain_step = remain_ff - 8'd1;
                  res.action  = ACT_ACK;
               end else begin
                  remain_step = 8'd0;
                  res.action  = ACT_NACK;
               end
            end
            ST_DATA_RNAK: begin
               res.rx_valid = 1'b1;
               res.rx_value = s1_req_ff.data_byte;
               res.rx_slot  = 6'(rx_pos_ff);
               rx_pos_step  = rx_inc(rx_pos_ff);
               op_pos_step  = op_adv;
               res.done_res = (nxt_addr == END_MARK);
               res.action   = (nxt_addr == END_MARK) ? ACT_STOP : ACT_RESTART;
            end
            default: begin
               res.fault = 1'b1;
            end
         endcase
      end
   end

   assign op_pos_in  = s1_fire ? op_pos_step  : op_pos_ff;
   assign tx_pos_in  = s1_fire ? tx_pos_step  : tx_pos_ff;
   assign rx_pos_in  = s1_fire ? rx_pos_step  : rx_pos_ff;
   assign rd_pend_in = s1_fire ? rd_pend_step : rd_pend_ff;
   assign remain_in  = s1_fire ? remain_step  : remain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         op_pos_ff  <= '0;
         tx_pos_ff  <= '0;
         rx_pos_ff  <= '0;
         rd_pend_ff <= 1'b0;
         remain_ff  <= 8'd0;
      end else begin
         // an empty read stage takes a request even while the response waits
         if (!req_stall) begin
            s1_vld_ff <= req_accept;
         end
         if (s1_fire) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         op_pos_ff  <= op_pos_in;
         tx_pos_ff  <= tx_pos_in;
         rx_pos_ff  <= rx_pos_in;
         rd_pend_ff <= rd_pend_in;
         remain_ff  <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ----- sv/i2cseq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module i2cseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/i2cseq_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
module i2cseq_check (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire i2cseq_pkg::req_type  req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire i2cseq_pkg::rsp_type  rsp_data
);
   import i2cseq_pkg::*;

   logic unused_in;
   assign unused_in = req_valid ^ req_stall ^ (^req_data);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |->
         rsp_data.action == ACT_NONE && !rsp_data.rx_valid && !rsp_data.done_res)
      else $error("fault response carries an action");

   a_done_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.action == ACT_STOP)
      else $error("done without stop");

   a_send_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_SEND |-> rsp_data.send_value == 8'd0)
      else $error("send value outside a send");

   a_rx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rx_valid |->
         rsp_data.rx_value == 8'd0 && rsp_data.rx_slot == 6'd0)
      else $error("receive fields set without a received byte");

endmodule

bind i2c_master_op_list_sequencer i2cseq_check u_i2cseq_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
